// File: hw/rtl/bba_pkg.sv
package bba_pkg;

  localparam int ADDR_W = 12;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int UPC_W  = 3;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  typedef logic [UPC_W-1:0] bba_upc_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] block_addr;
    logic              bit_value;
    logic [ADDR_W-1:0] range_end;
  } bba_req_t;

  typedef struct packed {
    logic              bit_read;
    logic [ADDR_W-1:0] found_addr;
    logic [STAT_W-1:0] status;
  } bba_rsp_t;

  // datapath micro-operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_READ,
    OP_RW,
    OP_SCAN,
    OP_BAD,
    OP_EMIT
  } bba_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_BAD,
    C_FIND,
    C_SCAN_MORE,
    C_OUT_BUSY
  } bba_cond_t;

  typedef struct packed {
    bba_op_t   op;
    bba_cond_t cond;
    bba_upc_t  tgt;
  } bba_ctl_t;

  typedef struct packed {
    logic no_req;
    logic bad;
    logic find;
    logic scan_more;
    logic out_busy;
  } bba_flags_t;

endpackage

// File: hw/rtl/bitmap_block_allocator.sv
// Used/free bitmap over MAP_BLOCKS blocks, held as WORD_BITS-bit words in one
// RAM with a write and a read port; the whole map reads as free right after
// reset through per-word written flags, so no clearing pass is needed.
// Requests read a bit, write a bit, or find the lowest free block in an
// inclusive address range; block 0 is the reserved header and is rejected as
// an operand. A small microprogram steps the datapath: it checks a request,
// then rejects it or reads its word, then reads or writes the bit, or for a
// find scans words (one word read per cycle, at most MAP_BLOCKS / WORD_BITS
// rounded up), and then emits the result into an output register, so the next
// request is taken while an earlier result still waits.
module bitmap_block_allocator #(
  parameter int MAP_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::bba_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::bba_rsp_t out_data
);
  import bba_pkg::*;

  bba_ctl_t   ctl;
  bba_flags_t flags;

  bba_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  bba_datapath #(
    .MAP_BLOCKS (MAP_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .flags     (flags),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bba_useq.sv
module bba_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  bba_pkg::bba_flags_t flags,
  output bba_pkg::bba_ctl_t   ctl
);
  import bba_pkg::*;

  localparam bba_upc_t U_IDLE  = 3'd0;
  localparam bba_upc_t U_CHECK = 3'd1;
  localparam bba_upc_t U_READ  = 3'd2;
  localparam bba_upc_t U_RW    = 3'd3;
  localparam bba_upc_t U_BAD   = 3'd4;
  localparam bba_upc_t U_SPARE = 3'd5;
  localparam bba_upc_t U_SCAN  = 3'd6;
  localparam bba_upc_t U_EMIT  = 3'd7;

  // microprogram: scan falls through into emit, emit wraps to idle
  function automatic bba_ctl_t rom(bba_upc_t a);
    bba_ctl_t w;
    case (a)
      U_IDLE:  w = '{op: OP_ACCEPT, cond: C_NO_REQ,    tgt: U_IDLE};
      U_CHECK: w = '{op: OP_NOP,    cond: C_BAD,       tgt: U_BAD};
      U_READ:  w = '{op: OP_READ,   cond: C_FIND,      tgt: U_SCAN};
      U_RW:    w = '{op: OP_RW,     cond: C_ALWAYS,    tgt: U_EMIT};
      U_BAD:   w = '{op: OP_BAD,    cond: C_ALWAYS,    tgt: U_EMIT};
      U_SPARE: w = '{op: OP_NOP,    cond: C_ALWAYS,    tgt: U_IDLE};
      U_SCAN:  w = '{op: OP_SCAN,   cond: C_SCAN_MORE, tgt: U_SCAN};
      U_EMIT:  w = '{op: OP_EMIT,   cond: C_OUT_BUSY,  tgt: U_EMIT};
      default: w = '{op: OP_NOP,    cond: C_ALWAYS,    tgt: U_IDLE};
    endcase
    return w;
  endfunction

  bba_upc_t upc_r, upc_nxt;
  logic     take;

  assign ctl = rom(upc_r);

  always_comb begin
    case (ctl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_REQ:    take = flags.no_req;
      C_BAD:       take = flags.bad;
      C_FIND:      take = flags.find;
      C_SCAN_MORE: take = flags.scan_more;
      C_OUT_BUSY:  take = flags.out_busy;
      default:     take = 1'b0;
    endcase
    upc_nxt = take ? ctl.tgt : bba_upc_t'(upc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: hw/rtl/bba_datapath.sv
module bba_datapath #(
  parameter int MAP_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bba_pkg::bba_ctl_t   ctl,
  output bba_pkg::bba_flags_t flags,
  input  logic                in_valid,
  output logic                in_ready,
  input  bba_pkg::bba_req_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bba_pkg::bba_rsp_t   out_data
);
  import bba_pkg::*;

  localparam int MAP_WORDS = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIDX_W    = $clog2(WORD_BITS);
  localparam logic [WIDX_W-1:0] LAST_W   = WIDX_W'(MAP_WORDS - 1);
  localparam logic [BIDX_W-1:0] TOP_BIT  = BIDX_W'(WORD_BITS - 1);
  localparam logic [ADDR_W-1:0] WORD_INC = ADDR_W'(WORD_BITS);

  function automatic logic [WIDX_W-1:0] word_of(logic [ADDR_W-1:0] a);
    return WIDX_W'(32'(a) / WORD_BITS);
  endfunction

  function automatic logic [BIDX_W-1:0] bit_of(logic [ADDR_W-1:0] a);
    return BIDX_W'(32'(a) % WORD_BITS);
  endfunction

  function automatic logic addr_good(logic [ADDR_W-1:0] a);
    return (a != '0) && (32'(a) < 32'(MAP_BLOCKS));
  endfunction

  bba_req_t              req_r;
  logic [WIDX_W-1:0]     ptr_r, first_w_r, last_w_r;
  logic [BIDX_W-1:0]     first_b_r, last_b_r;
  logic [ADDR_W-1:0]     base_r;
  bba_rsp_t              res_r, out_r;
  logic                  out_valid_r;
  logic [MAP_WORDS-1:0]  valid_r;
  logic                  rd_valid_r;

  logic                  accept;
  logic                  rd_en, wr_en;
  logic [WIDX_W-1:0]     raddr, ptr_next;
  logic [WORD_BITS-1:0]  ram_rdata, rdword, wdata;
  logic [BIDX_W-1:0]     lo, hi, hit_idx;
  logic                  hit, req_bad;
  logic                  rng_empty;
  logic                  emit_load;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WIDX_W)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ptr_r),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (ctl.op == OP_ACCEPT) && rst_n;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // words never written since reset read as all free
  assign rdword = rd_valid_r ? ram_rdata : '0;

  always_comb begin
    wdata = rdword;
    wdata[first_b_r] = req_r.bit_value;
  end

  assign ptr_next = (ptr_r == LAST_W) ? ptr_r : WIDX_W'(ptr_r + 1'b1);
  assign rd_en    = (ctl.op == OP_READ) || (ctl.op == OP_SCAN);
  assign raddr    = (ctl.op == OP_SCAN) ? ptr_next : ptr_r;
  assign wr_en    = (ctl.op == OP_RW) && (req_r.kind == KIND_WRITE);

  // range limits inside the word under scan
  assign lo = (ptr_r == first_w_r) ? first_b_r : '0;
  assign hi = (ptr_r == last_w_r) ? last_b_r : TOP_BIT;

  // a range that starts past its end holds no block
  assign rng_empty = (req_r.block_addr > req_r.range_end);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rng_empty && !rdword[i] && (BIDX_W'(i) >= lo) && (BIDX_W'(i) <= hi)) begin
        hit     = 1'b1;
        hit_idx = BIDX_W'(i);
      end
    end
  end

  always_comb begin
    case (req_r.kind)
      KIND_READ,
      KIND_WRITE: req_bad = !addr_good(req_r.block_addr);
      KIND_FIND:  req_bad = !addr_good(req_r.block_addr) || !addr_good(req_r.range_end);
      default:    req_bad = 1'b1;
    endcase
  end

  assign flags.no_req    = !in_valid;
  assign flags.bad       = req_bad;
  assign flags.find      = (req_r.kind == KIND_FIND);
  assign flags.scan_more = !hit && (ptr_r < last_w_r);
  assign flags.out_busy  = out_valid_r && !out_ready;

  assign emit_load = (ctl.op == OP_EMIT) && !(out_valid_r && !out_ready);

  // request and scan registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= in_data;
      ptr_r     <= word_of(in_data.block_addr);
      first_w_r <= word_of(in_data.block_addr);
      last_w_r  <= word_of(in_data.range_end);
      first_b_r <= bit_of(in_data.block_addr);
      last_b_r  <= bit_of(in_data.range_end);
      base_r    <= ADDR_W'(in_data.block_addr - ADDR_W'(bit_of(in_data.block_addr)));
    end else if (ctl.op == OP_SCAN) begin
      ptr_r  <= ptr_next;
      base_r <= ADDR_W'(base_r + WORD_INC);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_RW: begin
        res_r.bit_read   <= (req_r.kind == KIND_READ) ? rdword[first_b_r] : 1'b0;
        res_r.found_addr <= '0;
        res_r.status     <= ST_OK;
      end
      OP_BAD: begin
        res_r.bit_read   <= 1'b0;
        res_r.found_addr <= '0;
        res_r.status     <= ST_BAD;
      end
      OP_SCAN: begin
        res_r.bit_read   <= 1'b0;
        res_r.found_addr <= hit ? ADDR_W'(base_r + ADDR_W'(hit_idx)) : '0;
        res_r.status     <= hit ? ST_OK : ST_NONE;
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[ptr_r] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[raddr];
      end
    end
  end

endmodule
